>>> rtl/core/lpe_pkg.sv
// lpe_pkg: types, constants and helpers shared by the laguerre evaluator
// no dependencies; compiled first

package lpe_pkg;

	// fixed point constants, Q32.32
	localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
	localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] NEG_MIN = 64'h8000_0000_0000_0000;

	// numerator and quotient widths
	localparam int ACC_W = 128;
	localparam int QUO_W = 96;

	// divider: bits retired per cycle and cycle count
	localparam int DIV_BITS   = 8;
	localparam int DIV_CYCLES = QUO_W / DIV_BITS;
	localparam int DIV_CNT_W  = 4;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHK,
		S_LOAD,
		S_MUL,
		S_ACC,
		S_ABS,
		S_DIV,
		S_FIN,
		S_PUB
	} lpe_state_t;

	// controller to datapath
	typedef struct packed {
		logic       load_item;
		logic       ld_ops;
		logic       mul;
		logic       acc;
		logic       abs_val;
		logic       div_step;
		logic       finish;
		logic       publish;
		logic       term;
		logic [1:0] pp_idx;
	} lpe_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic trivial;
		logic ovf;
		logic last;
	} lpe_stat_t;

	// magnitude of a two's complement word
	function automatic logic [63:0] mag64(logic [63:0] v);
		return v[63] ? (~v + 64'd1) : v;
	endfunction

endpackage

>>> rtl/core/lpe_in_if.sv
// lpe_in_if: input channel, one beat carries a point and a degree
// no dependencies

interface lpe_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] point_x;
	logic signed [7:0]  degree;

	modport source(output valid, output point_x, output degree, input ready);
	modport sink(input valid, input point_x, input degree, output ready);
endinterface

>>> rtl/core/lpe_out_if.sv
// lpe_out_if: result channel, one beat carries the value and the clamp flag
// no dependencies

interface lpe_out_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] poly_value;
	logic               saturated;

	modport source(output valid, output poly_value, output saturated, input ready);
	modport sink(input valid, input poly_value, input saturated, output ready);
endinterface

>>> rtl/core/lpe_datapath.sv
// lpe_datapath: recurrence registers, shared 32x32 multiplier, accumulator,
// radix-256 restoring divider and result register; depends on lpe_pkg

module lpe_datapath #(
	parameter int MAX_DEGREE = 127
) (
	input  logic                clk,
	input  lpe_pkg::lpe_cmd_t   cmd,
	output lpe_pkg::lpe_stat_t  stat,
	input  logic signed [31:0]  point_x,
	input  logic signed [7:0]   degree,
	output logic signed [63:0]  poly_value,
	output logic                saturated
);
	import lpe_pkg::*;

	localparam int KW = $clog2(MAX_DEGREE + 1);

	logic [63:0]       xq_q, p_q, q_q, ma_q, mb_q, pp_q, res_q, out_val_q;
	logic [KW-1:0]     n_q, k_q, rem_q;
	logic              sg_q, neg_q, sat_q, trivial_q, out_sat_q;
	logic [ACC_W-1:0]  acc_q;
	logic [QUO_W-1:0]  div_q;

	logic [63:0]       xq_w, k64_w, coef_w, op_a_w, op_b_w, lo_w, step_res_w;
	logic [31:0]       deg_ext_w, deg_clip_w, a_half_w, b_half_w;
	logic [ACC_W-1:0]  pp_sh_w, mag_w;
	logic [KW-1:0]     k_inc_w, rem_nx_w;
	logic [QUO_W-1:0]  div_nx_w;
	logic              ovf_w;

	// input decode
	assign xq_w       = {{16{point_x[31]}}, point_x, 16'b0};
	assign deg_ext_w  = {{24{degree[7]}}, degree};
	assign deg_clip_w = ($signed(deg_ext_w) > MAX_DEGREE) ? 32'(MAX_DEGREE) : deg_ext_w;

	// recurrence operands
	assign k64_w  = 64'(k_q);
	assign coef_w = (((k64_w << 1) | 64'd1) << 32) - xq_q;
	assign op_a_w = cmd.term ? (k64_w << 32) : coef_w;
	assign op_b_w = cmd.term ? p_q : q_q;
	assign k_inc_w = k_q + {{(KW-1){1'b0}}, 1'b1};

	// partial product halves and alignment
	assign a_half_w = cmd.pp_idx[1] ? ma_q[63:32] : ma_q[31:0];
	assign b_half_w = cmd.pp_idx[0] ? mb_q[63:32] : mb_q[31:0];
	always_comb begin
		unique case (cmd.pp_idx)
			2'd0:    pp_sh_w = {64'b0, pp_q};
			2'd3:    pp_sh_w = {pp_q, 64'b0};
			default: pp_sh_w = {32'b0, pp_q, 32'b0};
		endcase
	end

	assign mag_w = acc_q[ACC_W-1] ? (~acc_q + 128'd1) : acc_q;

	// eight quotient bits per cycle
	always_comb begin
		logic [KW:0]      cur;
		logic [KW-1:0]    r;
		logic [QUO_W-1:0] dv;
		r  = rem_q;
		dv = div_q;
		for (int j = 0; j < DIV_BITS; j++) begin
			cur = {r, dv[QUO_W-1]};
			dv  = dv << 1;
			if (cur >= {1'b0, k_inc_w}) begin
				cur   = cur - {1'b0, k_inc_w};
				dv[0] = 1'b1;
			end
			r = cur[KW-1:0];
		end
		rem_nx_w = r;
		div_nx_w = dv;
	end

	// step result with clamp
	assign lo_w  = div_q[63:0];
	assign ovf_w = (|div_q[QUO_W-1:64]) ||
		(neg_q ? (lo_w[63] && (|lo_w[62:0])) : lo_w[63]);
	assign step_res_w = ovf_w ? (neg_q ? NEG_MIN : POS_MAX) :
		(neg_q ? (~lo_w + 64'd1) : lo_w);

	// datapath registers
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			xq_q  <= xq_w;
			n_q   <= deg_clip_w[KW-1:0];
			k_q   <= {{(KW-1){1'b0}}, 1'b1};
			p_q   <= ONE_Q32;
			q_q   <= ONE_Q32 - xq_w;
			sat_q <= 1'b0;
			trivial_q <= 1'b1;
			if (degree[7]) begin
				res_q <= 64'd0;
			end else if (point_x == 32'sd0 || degree == 8'sd0) begin
				res_q <= ONE_Q32;
			end else if (degree == 8'sd1) begin
				res_q <= ONE_Q32 - xq_w;
			end else begin
				res_q     <= ONE_Q32 - xq_w;
				trivial_q <= 1'b0;
			end
		end
		if (cmd.ld_ops) begin
			ma_q <= mag64(op_a_w);
			mb_q <= mag64(op_b_w);
			sg_q <= op_a_w[63] ^ op_b_w[63] ^ cmd.term;
			if (!cmd.term) begin
				acc_q <= '0;
			end
		end
		if (cmd.mul) begin
			pp_q <= {32'b0, a_half_w} * {32'b0, b_half_w};
		end
		if (cmd.acc) begin
			acc_q <= sg_q ? (acc_q - pp_sh_w) : (acc_q + pp_sh_w);
		end
		if (cmd.abs_val) begin
			neg_q <= acc_q[ACC_W-1];
			div_q <= mag_w[ACC_W-1:32];
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			div_q <= div_nx_w;
			rem_q <= rem_nx_w;
		end
		if (cmd.finish) begin
			res_q <= step_res_w;
			if (ovf_w) begin
				sat_q <= 1'b1;
			end else begin
				p_q <= q_q;
				q_q <= step_res_w;
				k_q <= k_inc_w;
			end
		end
		if (cmd.publish) begin
			out_val_q <= res_q;
			out_sat_q <= sat_q;
		end
	end

	assign stat.trivial = trivial_q;
	assign stat.ovf     = ovf_w;
	assign stat.last    = (k_inc_w == n_q);
	assign poly_value   = out_val_q;
	assign saturated    = out_sat_q;

endmodule

>>> rtl/core/lpe_ctrl.sv
// lpe_ctrl: sequencer for the recurrence, handshakes and output valid
// depends on lpe_pkg

module lpe_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  lpe_pkg::lpe_stat_t stat,
	output lpe_pkg::lpe_cmd_t  cmd
);
	import lpe_pkg::*;

	lpe_state_t            state_q, state_nx;
	logic [1:0]            pp_q, pp_nx;
	logic                  term_q, term_nx;
	logic [DIV_CNT_W-1:0]  cnt_q, cnt_nx;
	logic                  out_valid_q, out_valid_nx;

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pp_q        <= '0;
			term_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nx;
			pp_q        <= pp_nx;
			term_q      <= term_nx;
			cnt_q       <= cnt_nx;
			out_valid_q <= out_valid_nx;
		end
	end

	// next state and commands
	always_comb begin
		state_nx     = state_q;
		pp_nx        = pp_q;
		term_nx      = term_q;
		cnt_nx       = cnt_q;
		cmd          = '0;
		cmd.term     = term_q;
		cmd.pp_idx   = pp_q;
		in_ready     = 1'b0;
		out_valid_nx = out_valid_q && !out_ready;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_nx      = S_CHK;
				end
			end
			S_CHK: begin
				term_nx  = 1'b0;
				state_nx = stat.trivial ? S_PUB : S_LOAD;
			end
			S_LOAD: begin
				cmd.ld_ops = 1'b1;
				pp_nx      = 2'd0;
				state_nx   = S_MUL;
			end
			S_MUL: begin
				cmd.mul  = 1'b1;
				state_nx = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				pp_nx   = pp_q + 2'd1;
				if (pp_q == 2'd3) begin
					if (!term_q) begin
						term_nx  = 1'b1;
						state_nx = S_LOAD;
					end else begin
						state_nx = S_ABS;
					end
				end else begin
					state_nx = S_MUL;
				end
			end
			S_ABS: begin
				cmd.abs_val = 1'b1;
				cnt_nx      = '0;
				state_nx    = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_nx       = cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
					state_nx = S_FIN;
				end
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				term_nx    = 1'b0;
				state_nx   = (stat.ovf || stat.last) ? S_PUB : S_LOAD;
			end
			S_PUB: begin
				if (!out_valid_q || out_ready) begin
					cmd.publish  = 1'b1;
					out_valid_nx = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

>>> rtl/core/laguerre_polynomial_eval.sv
// Laguerre polynomial evaluator L_n(x): x is signed Q16.16, the result signed
// Q32.32, computed by the three-term recurrence on one shared 32x32 multiplier
// and an 8-bit-per-cycle divider. Negative n gives 0; n = 0 or x = 0 gives 1.0;
// n = 1 gives 1 - x; n above MAX_DEGREE is clamped. A step that overflows
// clamps the value, raises saturated and ends the item. Each step loads the
// operands and forms two 64x64 products as four 32x32 partial products each,
// multiplying and accumulating each partial product in turn, then takes the
// magnitude, runs the divider and updates the recurrence. A finished result
// waits until the output register is free. One item is in flight at a time;
// a new item is taken while the last result still waits in the output register.
// depends on lpe_pkg, lpe_in_if, lpe_out_if, lpe_ctrl, lpe_datapath

module laguerre_polynomial_eval #(
	parameter int MAX_DEGREE = 127
) (
	input logic       clk,
	input logic       arst_n,
	lpe_in_if.sink    item,
	lpe_out_if.source result
);
	import lpe_pkg::*;

	lpe_cmd_t  cmd;
	lpe_stat_t stat;

	lpe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lpe_datapath #(
		.MAX_DEGREE (MAX_DEGREE)
	) u_datapath (
		.clk        (clk),
		.cmd        (cmd),
		.stat       (stat),
		.point_x    (item.point_x),
		.degree     (item.degree),
		.poly_value (result.poly_value),
		.saturated  (result.saturated)
	);

endmodule

>>> rtl/core/lpe_checker.sv
// lpe_checker: port-level assertions for the laguerre evaluator, plus bind
// depends on laguerre_polynomial_eval

module lpe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] poly_value,
	input logic        saturated
);

	// a waiting result beat holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(poly_value) && $stable(saturated))
		else $error("result payload changed while stalled");

	// one item at a time: input closes right after an accepted beat
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in flight");

	// a clamped result is one of the two bounds
	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |->
		(poly_value == 64'h7FFF_FFFF_FFFF_FFFF) || (poly_value == 64'h8000_0000_0000_0000))
		else $error("saturated result is not a bound");

endmodule

bind laguerre_polynomial_eval lpe_checker u_lpe_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (item.valid),
	.in_ready   (item.ready),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.poly_value (result.poly_value),
	.saturated  (result.saturated)
);
